// ===== hw/rtl/four_level_page_table_walker_unit_macros.svh =====
// Assertion macros for the page table walker RTL top level.
// Define NO_ASSERTIONS to compile every check away.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PTW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("page table walker check failed");
`define PTW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("page table walker check failed");
`else
`define PTW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PTW_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/flptw_pkg.sv =====
// Types, constants and the microcode program of the page table walker.
// Used by the sequencer, the datapath and the top level.
`timescale 1ns / 1ps
package flptw_pkg;

  localparam int MEM_WORDS         = 4096;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int MEM_AW            = $clog2(MEM_WORDS);
  localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
  localparam int PAGE_W            = MEM_AW - IDX_W;
  localparam int TABLE_PAGES       = MEM_WORDS / ENTRIES_PER_TABLE;

  localparam int WORD_W   = 64;
  localparam int WIDX_W   = 12;
  localparam int VA_W     = 48;
  localparam int PA_W     = 52;
  localparam int ROOT_W   = 3;
  localparam int PFN_W    = PA_W - 12;
  localparam int LVL_W    = 2;
  localparam int OFF_4K_W = 12;
  localparam int OFF_2M_W = OFF_4K_W + IDX_W;
  localparam int OFF_1G_W = OFF_2M_W + IDX_W;
  localparam int BIT_PRESENT = 0;
  localparam int BIT_LARGE   = 7;

  localparam logic [LVL_W-1:0] LVL_TOP = 2'd3;
  localparam logic [LVL_W-1:0] LVL_1G  = 2'd2;
  localparam logic [LVL_W-1:0] LVL_2M  = 2'd1;
  localparam logic [LVL_W-1:0] LVL_4K  = 2'd0;

  typedef enum logic [2:0] {
    ST_MAPPED  = 3'd0,
    ST_ABSENT  = 3'd1,
    ST_HIGH    = 3'd2,
    ST_OUTSIDE = 3'd3,
    ST_WRITTEN = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SZ_4K = 2'd0,
    SZ_2M = 2'd1,
    SZ_1G = 2'd2
  } psize_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_WR   = 3'd1,
    S_CHK  = 3'd2,
    S_RD   = 3'd3,
    S_EV   = 3'd4
  } step_t;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_WRITE = 3'd1,
    OP_START = 3'd2,
    OP_READ  = 3'd3,
    OP_EVAL  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    C_NEXT     = 2'd0,
    C_DISPATCH = 2'd1,
    C_DONE     = 2'd2
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t next;
    step_t on_done;
  } ucode_t;

  typedef struct packed {
    op_t op;
  } ctl_t;

  typedef struct packed {
    logic done;
  } dp_stat_t;

  function automatic ucode_t ucode_rom(step_t s);
    ucode_t cw;
    unique case (s)
      S_IDLE:  cw = '{op: OP_IDLE,  cond: C_DISPATCH, next: S_IDLE, on_done: S_IDLE};
      S_WR:    cw = '{op: OP_WRITE, cond: C_NEXT,     next: S_IDLE, on_done: S_IDLE};
      S_CHK:   cw = '{op: OP_START, cond: C_DONE,     next: S_RD,   on_done: S_IDLE};
      S_RD:    cw = '{op: OP_READ,  cond: C_DONE,     next: S_EV,   on_done: S_IDLE};
      S_EV:    cw = '{op: OP_EVAL,  cond: C_DONE,     next: S_RD,   on_done: S_IDLE};
      default: cw = '{op: OP_IDLE,  cond: C_NEXT,     next: S_IDLE, on_done: S_IDLE};
    endcase
    return cw;
  endfunction

endpackage

// ===== hw/rtl/flptw_seq.sv =====
// Microcode sequencer: step register, control store lookup and branch logic.
// Depends on flptw_pkg.
`timescale 1ns / 1ps
module flptw_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_command,
  input  flptw_pkg::dp_stat_t stat,
  output flptw_pkg::ctl_t     ctl,
  output logic                busy
);
  import flptw_pkg::*;

  step_t  step_r;
  step_t  step_nxt;
  ucode_t cw;

  assign cw = ucode_rom(step_r);

  always_comb begin
    step_nxt = cw.next;
    unique case (cw.cond)
      C_DISPATCH: begin
        if (start) begin
          step_nxt = in_command ? S_CHK : S_WR;
        end
      end
      C_DONE: begin
        if (stat.done) begin
          step_nxt = cw.on_done;
        end
      end
      default: step_nxt = cw.next;
    endcase
  end

  always_comb begin
    ctl.op = cw.op;
    busy   = (step_r != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== hw/rtl/flptw_dp.sv =====
// Datapath: table memory, walk registers, root register and result registers.
// Depends on flptw_pkg; driven by the control word from flptw_seq.
`timescale 1ns / 1ps
module flptw_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  flptw_pkg::ctl_t                   ctl,
  input  logic                              start,
  input  logic [flptw_pkg::WIDX_W-1:0]      in_word_index,
  input  logic [flptw_pkg::WORD_W-1:0]      in_word_data,
  input  logic [flptw_pkg::VA_W-1:0]        in_virt_addr,
  input  logic                              cfg_we,
  input  logic [flptw_pkg::ROOT_W-1:0]      cfg_wdata,
  output flptw_pkg::dp_stat_t               stat,
  output logic                              out_valid,
  output logic [2:0]                        out_status,
  output logic [flptw_pkg::PA_W-1:0]        out_phys_addr,
  output logic [1:0]                        out_page_size
);
  import flptw_pkg::*;

  logic [WORD_W-1:0] table_mem [MEM_WORDS];
  logic [WORD_W-1:0] rdata_r;

  logic [ROOT_W-1:0] root_r;
  logic [WIDX_W-1:0] widx_r;
  logic [WORD_W-1:0] wdata_r;
  logic [VA_W-1:0]   va_r;
  logic [PFN_W-1:0]  page_r;
  logic [LVL_W-1:0]  lvl_r;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [PA_W-1:0]   out_phys_addr_r;
  psize_t            out_page_size_r;

  logic              done;
  status_t           res_status;
  logic [PA_W-1:0]   res_pa;
  psize_t            res_size;
  logic              outside;
  logic              wr_in_range;
  logic [IDX_W-1:0]  tbl_idx;
  logic [MEM_AW-1:0] raddr;
  logic [MEM_AW-1:0] waddr;

  assign outside     = (page_r >= PFN_W'(TABLE_PAGES));
  assign wr_in_range = (32'(widx_r) < 32'(MEM_WORDS));
  assign tbl_idx     = va_r[OFF_4K_W + IDX_W * int'(lvl_r) +: IDX_W];
  assign raddr       = {page_r[PAGE_W-1:0], tbl_idx};
  assign waddr       = MEM_AW'(widx_r);

  always_comb begin
    done       = 1'b0;
    res_status = ST_MAPPED;
    res_pa     = '0;
    res_size   = SZ_4K;
    unique case (ctl.op)
      OP_WRITE: begin
        done       = 1'b1;
        res_status = ST_WRITTEN;
      end
      OP_START: begin
        if (va_r[VA_W-1]) begin
          done       = 1'b1;
          res_status = ST_HIGH;
        end
      end
      OP_READ: begin
        if (outside) begin
          done       = 1'b1;
          res_status = ST_OUTSIDE;
        end
      end
      OP_EVAL: begin
        if (!rdata_r[BIT_PRESENT]) begin
          done       = 1'b1;
          res_status = ST_ABSENT;
        end else if (lvl_r == LVL_1G && rdata_r[BIT_LARGE]) begin
          done     = 1'b1;
          res_pa   = {rdata_r[PA_W-1:OFF_1G_W], va_r[OFF_1G_W-1:0]};
          res_size = SZ_1G;
        end else if (lvl_r == LVL_2M && rdata_r[BIT_LARGE]) begin
          done     = 1'b1;
          res_pa   = {rdata_r[PA_W-1:OFF_2M_W], va_r[OFF_2M_W-1:0]};
          res_size = SZ_2M;
        end else if (lvl_r == LVL_4K) begin
          done   = 1'b1;
          res_pa = {rdata_r[PA_W-1:OFF_4K_W], va_r[OFF_4K_W-1:0]};
        end
      end
      default: done = 1'b0;
    endcase
  end

  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (ctl.op == OP_WRITE && wr_in_range) begin
      table_mem[waddr] <= wdata_r;
    end
    if (ctl.op == OP_READ) begin
      rdata_r <= table_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_IDLE && start) begin
      widx_r  <= in_word_index;
      wdata_r <= in_word_data;
      va_r    <= in_virt_addr;
    end
    if (ctl.op == OP_START) begin
      page_r <= PFN_W'(root_r);
      lvl_r  <= LVL_TOP;
    end else if (ctl.op == OP_EVAL && !done) begin
      page_r <= rdata_r[PA_W-1:OFF_4K_W];
      lvl_r  <= lvl_r - 2'd1;
    end
    if (done) begin
      out_status_r    <= res_status;
      out_phys_addr_r <= res_pa;
      out_page_size_r <= res_size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        root_r <= cfg_wdata;
      end
      out_valid_r <= done;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_phys_addr = out_phys_addr_r;
  assign out_page_size = out_page_size_r;

endmodule

// ===== hw/rtl/four_level_page_table_walker_unit.sv =====
// Channel   Handshake              Payload
// input     start, busy            in_command, in_word_index, in_word_data, in_virt_addr
// result    out_valid (strobe)     out_status, out_phys_addr, out_page_size
// config    cfg_we                 cfg_wdata (root page)
//
// A write transaction keeps busy high for its single write step; its result strobes on the cycle after.
// A translation takes a check step plus a read and an evaluate step per level; a table
// beyond memory ends the walk in its read step.
// The result strobes in the first cycle with busy low.
// Reset clears the sequencer, root page and result strobe; the table memory is not cleared.
// A new transaction may start in the cycle a result is strobed; results are never held.
`timescale 1ns / 1ps
`include "four_level_page_table_walker_unit_macros.svh"
module four_level_page_table_walker_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_command,
  input  logic [flptw_pkg::WIDX_W-1:0]      in_word_index,
  input  logic [flptw_pkg::WORD_W-1:0]      in_word_data,
  input  logic [flptw_pkg::VA_W-1:0]        in_virt_addr,
  input  logic                              cfg_we,
  input  logic [flptw_pkg::ROOT_W-1:0]      cfg_wdata,
  output logic                              out_valid,
  output logic [2:0]                        out_status,
  output logic [flptw_pkg::PA_W-1:0]        out_phys_addr,
  output logic [1:0]                        out_page_size
);
  import flptw_pkg::*;

  ctl_t     ctl;
  dp_stat_t stat;

  flptw_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_command(in_command),
    .stat      (stat),
    .ctl       (ctl),
    .busy      (busy)
  );

  flptw_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .start        (start),
    .in_word_index(in_word_index),
    .in_word_data (in_word_data),
    .in_virt_addr (in_virt_addr),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_phys_addr(out_phys_addr),
    .out_page_size(out_page_size)
  );

  `PTW_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `PTW_ASSERT_NXT(a_strobe_single, clk, rst_n, out_valid, !out_valid)
  `PTW_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_valid, !busy)
  `PTW_ASSERT_IMP(a_fault_zero, clk, rst_n, out_valid && out_status != ST_MAPPED,
                  out_phys_addr == '0 && out_page_size == SZ_4K)

endmodule

// ===== dv/page_walk_tb_pkg.sv =====
// Command codes shared by the page table walker testbench files.
// Depends on nothing; compiled before the checker and the testbench top.
`timescale 1ns / 1ps
package page_walk_tb_pkg;

  typedef enum logic {
    CMD_WRITE     = 1'b0,
    CMD_TRANSLATE = 1'b1
  } cmd_t;

endpackage

// ===== dv/page_walk_checker.sv =====
// Checker for the page table walker: keeps its own table memory and root page, predicts
// each transaction's result and compares it with the strobed output.
// Depends on flptw_pkg from the RTL and on page_walk_tb_pkg.
`timescale 1ns / 1ps
module page_walk_checker
  import flptw_pkg::*;
  import page_walk_tb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic                in_command,
  input  logic [WIDX_W-1:0]   in_word_index,
  input  logic [WORD_W-1:0]   in_word_data,
  input  logic [VA_W-1:0]     in_virt_addr,
  input  logic                cfg_we,
  input  logic [ROOT_W-1:0]   cfg_wdata,
  input  logic                out_valid,
  input  logic [2:0]          out_status,
  input  logic [PA_W-1:0]     out_phys_addr,
  input  logic [1:0]          out_page_size,
  output int                  mismatch_count = 0,
  output int                  walks_pending = 0
);

  typedef struct packed {
    status_t          status;
    logic [PA_W-1:0]  phys;
    psize_t           size;
  } walk_result_t;

  logic [WORD_W-1:0] table_copy [MEM_WORDS];
  logic [ROOT_W-1:0] root_page = '0;
  walk_result_t      expected_walks [$];
  int                errors = 0;

  function automatic walk_result_t translate_va(logic [VA_W-1:0] va);
    logic [PFN_W-1:0]  pg;
    logic [WORD_W-1:0] e;
    logic [IDX_W-1:0]  idx;
    if (va[VA_W-1]) begin
      return '{ST_HIGH, '0, SZ_4K};
    end
    pg = PFN_W'(root_page);
    e = '0;
    for (int lvl = LVL_TOP; lvl >= 0; lvl--) begin
      idx = va[OFF_4K_W + IDX_W * lvl +: IDX_W];
      if (pg >= TABLE_PAGES) begin
        return '{ST_OUTSIDE, '0, SZ_4K};
      end
      e = table_copy[{pg[PAGE_W-1:0], idx}];
      if (!e[BIT_PRESENT]) begin
        return '{ST_ABSENT, '0, SZ_4K};
      end
      if (lvl == LVL_1G && e[BIT_LARGE]) begin
        return '{ST_MAPPED, {e[PA_W-1:OFF_1G_W], va[OFF_1G_W-1:0]}, SZ_1G};
      end
      if (lvl == LVL_2M && e[BIT_LARGE]) begin
        return '{ST_MAPPED, {e[PA_W-1:OFF_2M_W], va[OFF_2M_W-1:0]}, SZ_2M};
      end
      pg = e[PA_W-1:OFF_4K_W];
    end
    return '{ST_MAPPED, {e[PA_W-1:OFF_4K_W], va[OFF_4K_W-1:0]}, SZ_4K};
  endfunction

  always @(posedge clk) begin : monitor
    walk_result_t exp_r;
    if (!rst_n) begin
      root_page = '0;
      expected_walks.delete();
    end else begin
      if (out_valid) begin
        if (expected_walks.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected result st=%0d pa=%h sz=%0d",
                     out_status, out_phys_addr, out_page_size);
          end
        end else begin
          exp_r = expected_walks.pop_front();
          if (out_status !== exp_r.status || out_phys_addr !== exp_r.phys ||
              out_page_size !== exp_r.size) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch exp st=%0d pa=%h sz=%0d got st=%0d pa=%h sz=%0d",
                       exp_r.status, exp_r.phys, exp_r.size,
                       out_status, out_phys_addr, out_page_size);
            end
          end
        end
      end
      if (start && !busy) begin
        if (in_command == CMD_WRITE) begin
          table_copy[in_word_index] = in_word_data;
          expected_walks.push_back('{ST_WRITTEN, '0, SZ_4K});
        end else begin
          expected_walks.push_back(translate_va(in_virt_addr));
        end
      end
      if (cfg_we) begin
        root_page = cfg_wdata;
      end
    end
    walks_pending  <= expected_walks.size();
    mismatch_count <= errors;
  end

endmodule

// ===== dv/four_level_page_table_walker_unit_tb.sv =====
// Testbench top for the page table walker: drives directed and random table writes and
// translations, changes the root page between phases and gives the verdict.
// Depends on the RTL, flptw_pkg, page_walk_tb_pkg and page_walk_checker.
`timescale 1ns / 1ps
module four_level_page_table_walker_unit_tb;
  import flptw_pkg::*;
  import page_walk_tb_pkg::*;

  localparam int QUIET_LIMIT = 500;
  localparam int PHASE_ITEMS = 171;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_command = 1'b0;
  logic [WIDX_W-1:0]   in_word_index = '0;
  logic [WORD_W-1:0]   in_word_data = '0;
  logic [VA_W-1:0]     in_virt_addr = '0;
  logic                cfg_we = 1'b0;
  logic [ROOT_W-1:0]   cfg_wdata = '0;
  logic                out_valid;
  logic [2:0]          out_status;
  logic [PA_W-1:0]     out_phys_addr;
  logic [1:0]          out_page_size;
  int                  mismatch_count;
  int                  walks_pending;

  logic [WORD_W-1:0]   stim_mem [MEM_WORDS];
  bit                  stim_written [MEM_WORDS];
  logic [ROOT_W-1:0]   root_now = '0;
  bit                  sender_idles = 1'b1;
  int                  items_sent = 0;
  int                  quiet_cycles = 0;

  always #1 clk = ~clk;

  four_level_page_table_walker_unit uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_word_index (in_word_index),
    .in_word_data  (in_word_data),
    .in_virt_addr  (in_virt_addr),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_phys_addr (out_phys_addr),
    .out_page_size (out_page_size)
  );

  page_walk_checker walk_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_word_index  (in_word_index),
    .in_word_data   (in_word_data),
    .in_virt_addr   (in_virt_addr),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_phys_addr  (out_phys_addr),
    .out_page_size  (out_page_size),
    .mismatch_count (mismatch_count),
    .walks_pending  (walks_pending)
  );

  function automatic logic [WORD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [VA_W-1:0] make_va(logic [8:0] l4, logic [8:0] l3,
                                               logic [8:0] l2, logic [8:0] l1,
                                               logic [11:0] off);
    return {l4, l3, l2, l1, off};
  endfunction

  // Mostly present entries pointing inside the table memory, some large pages with full
  // frames, some absent entries and some pointers beyond the memory.
  function automatic logic [WORD_W-1:0] random_entry();
    logic [WORD_W-1:0] e;
    e = rand64();
    e[BIT_PRESENT] = ($urandom_range(0, 99) < 88);
    e[BIT_LARGE] = ($urandom_range(0, 3) == 0);
    if (!e[BIT_LARGE] && $urandom_range(0, 99) < 85) begin
      e[PA_W-1:OFF_4K_W+PAGE_W] = '0;
    end
    return e;
  endfunction

  function automatic logic [VA_W-1:0] random_walk_va();
    logic [VA_W-1:0] va;
    va = VA_W'(rand64());
    va[VA_W-1] = 1'b0;
    for (int lvl = 0; lvl < 4; lvl++) begin
      if ($urandom_range(0, 99) < 60) begin
        va[OFF_4K_W + IDX_W * lvl +: IDX_W] = IDX_W'($urandom_range(0, 3));
      end
    end
    return va;
  endfunction

  // Returns the first table word on the walk of va that was never written, or -1.
  function automatic int missing_word(logic [VA_W-1:0] va);
    logic [PFN_W-1:0]  pg;
    logic [WORD_W-1:0] e;
    logic [MEM_AW-1:0] w;
    pg = PFN_W'(root_now);
    for (int lvl = LVL_TOP; lvl >= 0; lvl--) begin
      if (pg >= TABLE_PAGES) begin
        return -1;
      end
      w = {pg[PAGE_W-1:0], va[OFF_4K_W + IDX_W * lvl +: IDX_W]};
      if (!stim_written[w]) begin
        return int'(w);
      end
      e = stim_mem[w];
      if (!e[BIT_PRESENT] || ((lvl == LVL_1G || lvl == LVL_2M) && e[BIT_LARGE])) begin
        return -1;
      end
      pg = e[PA_W-1:OFF_4K_W];
    end
    return -1;
  endfunction

  task automatic send_item(cmd_t cmd, logic [WIDX_W-1:0] idx, logic [WORD_W-1:0] data,
                           logic [VA_W-1:0] va);
    in_command    <= cmd;
    in_word_index <= idx;
    in_word_data  <= data;
    in_virt_addr  <= va;
    start         <= 1'b1;
    if (cmd == CMD_WRITE) begin
      stim_mem[idx] = data;
      stim_written[idx] = 1'b1;
    end
    items_sent++;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic write_word(logic [WIDX_W-1:0] idx, logic [WORD_W-1:0] data);
    send_item(CMD_WRITE, idx, data, VA_W'(rand64()));
  endtask

  task automatic translate(logic [VA_W-1:0] va);
    send_item(CMD_TRANSLATE, WIDX_W'($urandom), rand64(), va);
  endtask

  task automatic set_root(logic [ROOT_W-1:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (walks_pending != 0 || busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    root_now = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int                pick;
    int                w;
    logic [VA_W-1:0]   va;
    logic [ROOT_W-1:0] roots [6];
    roots = '{3'd0, 3'd7, ROOT_W'($urandom_range(1, 6)), 3'd0,
              ROOT_W'($urandom_range(0, 7)), 3'd7};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Hand-built tables under root page 0: pages 1 to 3 hold the lower levels.
    write_word(12'd0, 64'h0);
    write_word(12'd1, 64'h0000_0000_0000_1001);
    write_word(12'd514, 64'h0000_0000_0000_2001);
    write_word(12'd515, 64'h000F_FFFF_C000_0081);
    write_word(12'd1028, 64'h0000_0000_0000_3001);
    write_word(12'd1029, 64'h000F_FFFF_FFE0_0081);
    write_word(12'd1542, 64'hFFFF_FFFF_FFFF_FFFF);
    write_word(12'd1543, 64'hFFFF_FFFF_FFFF_FFFE);
    write_word(12'd8, 64'h0000_0000_0000_1081);
    write_word(12'd9, 64'h0000_0000_0000_8001);
    write_word(12'd255, 64'h0);
    write_word(12'd4095, 64'hFFFF_FFFF_FFFF_FFFF);
    write_word(12'd3839, 64'hFFFF_FFFF_FFFF_FFFF);
    translate(48'h0);
    translate(make_va(9'd1, 9'd2, 9'd4, 9'd6, 12'hfff));
    translate(make_va(9'd1, 9'd3, 9'h1ff, 9'h1ff, 12'hfff));
    translate(make_va(9'd1, 9'd2, 9'd5, 9'h155, 12'habc));
    translate(make_va(9'd1, 9'd2, 9'd4, 9'd7, 12'h0));
    translate(make_va(9'd8, 9'd2, 9'd4, 9'd6, 12'h123));
    translate(make_va(9'd9, 9'd0, 9'd0, 9'd0, 12'h0));
    translate(make_va(9'd255, 9'h1ff, 9'h1ff, 9'h1ff, 12'hfff));
    translate(48'h8000_0000_0000);
    translate(48'hFFFF_FFFF_FFFF);
    set_root(3'd7);
    translate(make_va(9'd255, 9'd0, 9'd0, 9'd0, 12'h0));

    for (int p = 0; p < 6; p++) begin
      set_root(roots[p]);
      sender_idles = (p != 5);
      pick = items_sent + PHASE_ITEMS;
      while (items_sent < pick) begin
        case ($urandom_range(0, 99)) inside
          [0:14]: begin
            if ($urandom_range(0, 1) == 0) begin
              write_word(WIDX_W'($urandom), random_entry());
            end else begin
              write_word({PAGE_W'($urandom), IDX_W'($urandom_range(0, 3))},
                         random_entry());
            end
          end
          [15:24]: begin
            va = VA_W'(rand64());
            va[VA_W-1] = 1'b1;
            translate(va);
          end
          default: begin
            va = random_walk_va();
            w = missing_word(va);
            while (w >= 0) begin
              write_word(WIDX_W'(w), random_entry());
              w = missing_word(va);
            end
            translate(va);
          end
        endcase
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (walks_pending != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && walks_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/flptw_pkg.sv
hw/rtl/flptw_seq.sv
hw/rtl/flptw_dp.sv
hw/rtl/four_level_page_table_walker_unit.sv
dv/page_walk_tb_pkg.sv
dv/page_walk_checker.sv
dv/four_level_page_table_walker_unit_tb.sv
